### design/egtm_pkg.sv
// Package for the exposure and gamma tone mapper: payload types, class codes,
// register indexes and the exp2 coefficient function. No dependencies.
package egtm_pkg;

  localparam int IN_W         = 24;
  localparam int OUT_BITS     = 8;
  localparam int FRAC_BITS_DF = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int EXP_W        = 10;
  localparam int IGAM_W       = 16;
  localparam int LOG_STEPS    = 16;
  localparam int LANE_LAT     = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA = 1'b1;

  localparam logic [EXP_W-1:0]  EXPOSURE_RST = '0;
  localparam logic [IGAM_W-1:0] INV_GAMMA_RST = 16'd4096;

  typedef enum logic [1:0] {
    PCLASS_NORMAL   = 2'd0,
    PCLASS_NEGATIVE = 2'd1,
    PCLASS_INVALID  = 2'd2
  } pix_class_t;

  typedef struct packed {
    logic signed [IN_W-1:0] red_in;
    logic signed [IN_W-1:0] green_in;
    logic signed [IN_W-1:0] blue_in;
    logic                   invalid_in;
  } in_pix_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_out;
    logic [OUT_BITS-1:0] green_out;
    logic [OUT_BITS-1:0] blue_out;
    logic [1:0]          pixel_class;
  } out_pix_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic invalid;
  } pix_flags_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > n) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Entry k is 2^(2^-k) in Q1.30, each a rounded-down root of the one before.
  function automatic logic [31:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int i = 1; i <= LOG_STEPS; i++) begin
      if (i <= k) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

### design/exposure_gamma_tone_mapper_top.sv
// Top level of the exposure and gamma tone mapper: configuration registers,
// flag pipeline, three channel lanes and the merging stage. Depends on egtm_pkg.
//
// The block takes one pixel in every clock cycle and never raises busy. Each
// result appears on out_data with out_valid high for one cycle; it is computed
// by the sixteen-step log2 and sixteen-step exp2 pipelines in each lane. The
// receiver cannot stall, so results must be taken as they come.
module exposure_gamma_tone_mapper_top #(
  parameter int FRAC_BITS = egtm_pkg::FRAC_BITS_DF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  egtm_pkg::in_pix_t                    in_data,
  output logic                                 out_valid,
  output egtm_pkg::out_pix_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [egtm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [egtm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int LAT = egtm_pkg::LANE_LAT;

  logic signed [egtm_pkg::EXP_W-1:0] exposure_r;
  logic [egtm_pkg::IGAM_W-1:0]       inv_gamma_r;
  egtm_pkg::pix_flags_t              flag_r [LAT];
  logic [egtm_pkg::OUT_BITS-1:0]     red_code, green_code, blue_code;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r  <= egtm_pkg::EXPOSURE_RST;
      inv_gamma_r <= egtm_pkg::INV_GAMMA_RST;
      for (int i = 0; i < LAT; i++) flag_r[i] <= '0;
    end else begin
      if (cfg_we && cfg_index == egtm_pkg::CFG_EXPOSURE) begin
        exposure_r <= cfg_wdata[egtm_pkg::EXP_W-1:0];
      end
      if (cfg_we && cfg_index == egtm_pkg::CFG_INV_GAMMA) begin
        inv_gamma_r <= cfg_wdata[egtm_pkg::IGAM_W-1:0];
      end
      flag_r[0].valid   <= start && !busy;
      flag_r[0].neg     <= in_data.red_in[egtm_pkg::IN_W-1] ||
                           in_data.green_in[egtm_pkg::IN_W-1] ||
                           in_data.blue_in[egtm_pkg::IN_W-1];
      flag_r[0].invalid <= in_data.invalid_in;
      for (int i = 1; i < LAT; i++) flag_r[i] <= flag_r[i-1];
    end
  end

  egtm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
    .clk(clk), .chan(in_data.red_in), .exposure(exposure_r),
    .inv_gamma(inv_gamma_r), .code(red_code)
  );

  egtm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
    .clk(clk), .chan(in_data.green_in), .exposure(exposure_r),
    .inv_gamma(inv_gamma_r), .code(green_code)
  );

  egtm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
    .clk(clk), .chan(in_data.blue_in), .exposure(exposure_r),
    .inv_gamma(inv_gamma_r), .code(blue_code)
  );

  egtm_merge u_merge (
    .clk(clk), .rst_n(rst_n), .flags(flag_r[LAT-1]),
    .red_code(red_code), .green_code(green_code), .blue_code(blue_code),
    .out_valid(out_valid), .out_data(out_data)
  );

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_class == egtm_pkg::PCLASS_NORMAL ||
                   out_data.pixel_class == egtm_pkg::PCLASS_NEGATIVE ||
                   out_data.pixel_class == egtm_pkg::PCLASS_INVALID))
    else $error("illegal pixel class");

  a_neg_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pixel_class == egtm_pkg::PCLASS_NEGATIVE) |->
      (out_data.red_out == '0 && out_data.blue_out == '0 && out_data.green_out == '1))
    else $error("negative pixel not pure green");

  a_inv_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pixel_class == egtm_pkg::PCLASS_INVALID) |->
      (out_data.red_out == '0 && out_data.green_out == '0 && out_data.blue_out == '1))
    else $error("invalid pixel not pure blue");

endmodule

### design/egtm_lane.sv
// One channel lane: leading-one normalize, bit-serial log2 pipeline, exponent
// multiply and table-driven exp2 pipeline. Depends on egtm_pkg.
module egtm_lane #(
  parameter int FRAC_BITS = egtm_pkg::FRAC_BITS_DF
) (
  input  logic                                clk,
  input  logic signed [egtm_pkg::IN_W-1:0]    chan,
  input  logic signed [egtm_pkg::EXP_W-1:0]   exposure,
  input  logic [egtm_pkg::IGAM_W-1:0]         inv_gamma,
  output logic [egtm_pkg::OUT_BITS-1:0]       code
);

  localparam int NS = egtm_pkg::LOG_STEPS;
  localparam int LW = 26;
  localparam int PW = LW + egtm_pkg::IGAM_W + 1;
  localparam int YW = PW - 12;
  localparam logic [egtm_pkg::OUT_BITS-1:0] FULL = '1;

  logic [4:0]  msb;
  logic [30:0] norm;

  logic [30:0] lm_r [NS+1];
  logic [15:0] lf_r [NS+1];
  logic [4:0]  lp_r [NS+1];
  logic        lz_r [NS+1];

  logic signed [LW-1:0] l_r, l_nxt;
  logic                 lzz_r;
  logic signed [YW-1:0] y_r;
  logic                 yz_r;
  logic signed [PW-1:0] prod;

  logic [30:0] et_r  [NS+1];
  logic [15:0] ef_r  [NS+1];
  logic [4:0]  esh_r [NS+1];
  logic        esat_r[NS+1];
  logic        ez_r  [NS+1];

  logic [14:0] neg_ip;
  logic [30:0] ts_r;
  logic        tsat_r, tz_r;
  logic [30+egtm_pkg::OUT_BITS:0] scaled;
  logic [egtm_pkg::OUT_BITS-1:0]  code_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < egtm_pkg::IN_W - 1; i++) begin
      if (chan[i]) msb = 5'(i);
    end
    norm = 31'({8'b0, chan[egtm_pkg::IN_W-2:0]} << (5'd30 - msb));
  end

  always_ff @(posedge clk) begin
    lm_r[0] <= norm;
    lf_r[0] <= '0;
    lp_r[0] <= msb;
    lz_r[0] <= (chan == '0);
  end

  for (genvar k = 0; k < NS; k++) begin : g_log
    logic [61:0] sq;
    logic [31:0] m2;
    assign sq = 62'(lm_r[k]) * 62'(lm_r[k]);
    assign m2 = sq[61:30];
    always_ff @(posedge clk) begin
      lf_r[k+1] <= {lf_r[k][14:0], m2[31]};
      lm_r[k+1] <= m2[31] ? m2[31:1] : m2[30:0];
      lp_r[k+1] <= lp_r[k];
      lz_r[k+1] <= lz_r[k];
    end
  end

  assign l_nxt = ((LW'(lp_r[NS]) - LW'(FRAC_BITS)) <<< 16) + LW'(lf_r[NS])
               + (LW'(exposure) <<< 12);
  assign prod  = PW'(l_r) * $signed({1'b0, inv_gamma});
  assign neg_ip = 15'(-y_r[YW-1:16]);

  always_ff @(posedge clk) begin
    l_r      <= l_nxt;
    lzz_r    <= lz_r[NS];
    y_r      <= prod[PW-1:12];
    yz_r     <= lzz_r;
    et_r[0]  <= 31'd1 << 30;
    ef_r[0]  <= y_r[15:0];
    esh_r[0] <= neg_ip[4:0];
    esat_r[0] <= !y_r[YW-1];
    ez_r[0]  <= yz_r || (y_r[YW-1] && (neg_ip > 15'd30));
  end

  for (genvar j = 0; j < NS; j++) begin : g_exp
    localparam logic [31:0] COEF = egtm_pkg::exp_coef(j + 1);
    logic [62:0] mp;
    assign mp = 63'(et_r[j]) * 63'(COEF);
    always_ff @(posedge clk) begin
      et_r[j+1]   <= ef_r[j][15-j] ? mp[60:30] : et_r[j];
      ef_r[j+1]   <= ef_r[j];
      esh_r[j+1]  <= esh_r[j];
      esat_r[j+1] <= esat_r[j];
      ez_r[j+1]   <= ez_r[j];
    end
  end

  assign scaled = (31 + egtm_pkg::OUT_BITS)'(ts_r) * (31 + egtm_pkg::OUT_BITS)'(FULL);

  always_ff @(posedge clk) begin
    ts_r   <= et_r[NS] >> esh_r[NS];
    tsat_r <= esat_r[NS];
    tz_r   <= ez_r[NS];
    if (tz_r) begin
      code_r <= '0;
    end else if (tsat_r) begin
      code_r <= FULL;
    end else begin
      code_r <= scaled[30+egtm_pkg::OUT_BITS-1:30];
    end
  end

  assign code = code_r;

endmodule

### design/egtm_merge.sv
// Merging stage: combines the three lane codes with the pixel flags into the
// registered result and its strobe. Depends on egtm_pkg.
module egtm_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  egtm_pkg::pix_flags_t              flags,
  input  logic [egtm_pkg::OUT_BITS-1:0]     red_code,
  input  logic [egtm_pkg::OUT_BITS-1:0]     green_code,
  input  logic [egtm_pkg::OUT_BITS-1:0]     blue_code,
  output logic                              out_valid,
  output egtm_pkg::out_pix_t                out_data
);

  localparam logic [egtm_pkg::OUT_BITS-1:0] FULL = '1;

  logic               valid_r;
  egtm_pkg::out_pix_t data_r, data_nxt;

  always_comb begin
    if (flags.neg) begin
      data_nxt.red_out     = '0;
      data_nxt.green_out   = FULL;
      data_nxt.blue_out    = '0;
      data_nxt.pixel_class = egtm_pkg::PCLASS_NEGATIVE;
    end else if (flags.invalid) begin
      data_nxt.red_out     = '0;
      data_nxt.green_out   = '0;
      data_nxt.blue_out    = FULL;
      data_nxt.pixel_class = egtm_pkg::PCLASS_INVALID;
    end else begin
      data_nxt.red_out     = red_code;
      data_nxt.green_out   = green_code;
      data_nxt.blue_out    = blue_code;
      data_nxt.pixel_class = egtm_pkg::PCLASS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= flags.valid;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
